FILE: design/bpc_pkg.sv
package bpc_pkg;

    localparam int REG_COUNT = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_AC1 = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AC2 = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_AC3 = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_AC4 = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_AC5 = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_AC6 = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_B1_B2 = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_MC_MD = 8'd7;

    localparam logic [15:0] RST_AC1 = 16'd408;
    localparam logic [15:0] RST_AC2 = 16'hFFB8;
    localparam logic [15:0] RST_AC3 = 16'hC7D1;
    localparam logic [15:0] RST_AC4 = 16'd32741;
    localparam logic [15:0] RST_AC5 = 16'd32757;
    localparam logic [15:0] RST_AC6 = 16'd23153;
    localparam logic [31:0] RST_B1_B2 = 32'd405667844;
    localparam logic [31:0] RST_MC_MD = 32'd3724086068;

    localparam logic signed [31:0] K_B6_OFFSET = 32'sd4000;
    localparam logic [31:0] K_B7_SCALE = 32'd50000;
    localparam logic signed [31:0] K_B4_OFFSET = 32'sd32768;
    localparam logic signed [31:0] K_P_SQ = 32'sd3038;
    localparam logic signed [31:0] K_P_LIN = -32'sd7357;
    localparam logic signed [31:0] K_P_OFS = 32'sd3791;
    localparam logic signed [31:0] P_MAX = 32'sd131071;
    localparam logic signed [31:0] T_MAX = 32'sd32767;
    localparam logic signed [31:0] T_MIN = -32'sd32768;

    // Quotient widths of the two dividers.
    localparam int DIV_T_NW = 27;
    localparam int DIV_P_NW = 32;
    localparam int DIV_DW = 32;

    // Signed division by four, rounding toward zero.
    function automatic logic signed [31:0] div4_trunc(input logic signed [31:0] v);
        logic signed [31:0] adj;
        adj = v + (v[31] ? 32'sd3 : 32'sd0);
        return adj >>> 2;
    endfunction

endpackage

FILE: design/bpc_div.sv
module bpc_div #(
    parameter int NW = 32,
    parameter int DW = 32,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side,
    output logic          out_valid,
    output logic [NW-1:0] quot,
    output logic [SW-1:0] out_side
);

    // One quotient bit per stage, restoring division.
    logic [NW-1:0] v_reg;
    logic [NW-1:0] n_reg [NW];
    logic [DW-1:0] r_reg [NW];
    logic [DW-1:0] d_reg [NW];
    logic [SW-1:0] s_reg [NW];

    for (genvar g = 0; g < NW; g++) begin : g_stage
        logic          v_in;
        logic [NW-1:0] n_in;
        logic [DW-1:0] r_in;
        logic [DW-1:0] d_in;
        logic [SW-1:0] s_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;
        logic [NW-1:0] n_next;
        logic [DW-1:0] r_next;

        if (g == 0) begin : g_first
            assign v_in = in_valid;
            assign n_in = num;
            assign r_in = '0;
            assign d_in = den;
            assign s_in = side;
        end else begin : g_rest
            assign v_in = v_reg[g-1];
            assign n_in = n_reg[g-1];
            assign r_in = r_reg[g-1];
            assign d_in = d_reg[g-1];
            assign s_in = s_reg[g-1];
        end

        always_comb
        begin
            trial = {r_in, n_in[NW-1]};
            diff = trial - {1'b0, d_in};
            ge = (trial >= {1'b0, d_in});
            r_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            n_next = {n_in[NW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[g] <= n_next;
                r_reg[g] <= r_next;
                d_reg[g] <= d_in;
                s_reg[g] <= s_in;
            end
        end
    end

    assign out_valid = v_reg[NW-1];
    assign quot = n_reg[NW-1];
    assign out_side = s_reg[NW-1];

endmodule

FILE: design/barometric_pressure_compensation_top.sv
// Barometric temperature and pressure compensation, fully pipelined.
//
// Input channel: raw_temperature and raw_pressure with in_valid/in_stall. A
// transfer happens on a rising edge with in_valid high and in_stall low.
// Output channel: temperature_tenths, pressure_pa and divide_error with
// out_valid/out_stall, transferred the same way.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data.
// cfg_ready is always high; indexes outside the eight calibration
// registers are ignored. Write calibration only while no readings are in
// flight.
//
// Throughput is one reading pair per cycle while the output is not stalled.
// The pipeline is built from the two bit-per-stage dividers (27 stages for
// the temperature divisor, 32 stages for the pressure divisor) plus nine
// arithmetic stages. When the receiver stalls a valid result, the whole
// pipeline holds and in_stall rises in the same cycle; nothing is dropped
// or repeated. Reset (rst_n, asynchronous) empties the pipeline and loads
// the factory calibration defaults.
module barometric_pressure_compensation_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [15:0]                       raw_temperature,
    input  logic [15:0]                       raw_pressure,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [15:0]                temperature_tenths,
    output logic [16:0]                       pressure_pa,
    output logic                              divide_error,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int NT = bpc_pkg::DIV_T_NW;
    localparam int NP = bpc_pkg::DIV_P_NW;
    localparam int DW = bpc_pkg::DIV_DW;
    localparam int SIDE_T_W = 32 + 16 + 2;
    localparam int SIDE_P_W = 16 + 2;

    // Calibration registers.
    logic [15:0] ac1_reg, ac2_reg, ac3_reg, ac4_reg, ac5_reg, ac6_reg;
    logic [31:0] b1b2_reg, mcmd_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac1_reg <= bpc_pkg::RST_AC1;
            ac2_reg <= bpc_pkg::RST_AC2;
            ac3_reg <= bpc_pkg::RST_AC3;
            ac4_reg <= bpc_pkg::RST_AC4;
            ac5_reg <= bpc_pkg::RST_AC5;
            ac6_reg <= bpc_pkg::RST_AC6;
            b1b2_reg <= bpc_pkg::RST_B1_B2;
            mcmd_reg <= bpc_pkg::RST_MC_MD;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bpc_pkg::REG_AC1: ac1_reg <= cfg_data[15:0];
                bpc_pkg::REG_AC2: ac2_reg <= cfg_data[15:0];
                bpc_pkg::REG_AC3: ac3_reg <= cfg_data[15:0];
                bpc_pkg::REG_AC4: ac4_reg <= cfg_data[15:0];
                bpc_pkg::REG_AC5: ac5_reg <= cfg_data[15:0];
                bpc_pkg::REG_AC6: ac6_reg <= cfg_data[15:0];
                bpc_pkg::REG_B1_B2: b1b2_reg <= cfg_data;
                bpc_pkg::REG_MC_MD: mcmd_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sign-extended coefficients, read directly by every stage. The user must
    // keep them steady while readings are in flight; nothing here enforces it.
    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    assign ac1 = {{16{ac1_reg[15]}}, ac1_reg};
    assign ac2 = {{16{ac2_reg[15]}}, ac2_reg};
    assign ac3 = {{16{ac3_reg[15]}}, ac3_reg};
    assign b1 = {{16{b1b2_reg[31]}}, b1b2_reg[31:16]};
    assign b2 = {{16{b1b2_reg[15]}}, b1b2_reg[15:0]};
    assign mc = {{16{mcmd_reg[31]}}, mcmd_reg[31:16]};
    assign md = {{16{mcmd_reg[15]}}, mcmd_reg[15:0]};

    // The whole pipeline advances unless a result waits at the output.
    logic en;
    assign en = !(out_valid && out_stall);
    assign in_stall = !en;

    // Stage 1: linear temperature term X1.
    logic signed [16:0] dt;
    logic signed [33:0] t_prod;
    logic signed [31:0] x1_next;
    logic               s1_v_reg;
    logic signed [31:0] s1_x1_reg;
    logic [15:0]        s1_up_reg;

    always_comb
    begin
        dt = $signed({1'b0, raw_temperature}) - $signed({1'b0, ac6_reg});
        t_prod = dt * $signed({1'b0, ac5_reg});
        x1_next = $signed(t_prod[31:0]) >>> 15;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x1_reg <= x1_next;
            s1_up_reg <= raw_pressure;
        end
    end

    // Temperature divider: MC * 2048 / (X1 + MD) on magnitudes, sign fixed
    // up afterwards.
    logic signed [31:0] den_t;
    logic signed [31:0] num_t;
    logic [31:0]        den_t_mag;
    logic [31:0]        num_t_mag;
    logic               neg_t;
    logic               err_t;
    logic [SIDE_T_W-1:0] side_t_in, side_t_out;
    logic               dt_v;
    logic [NT-1:0]      q_t;

    always_comb
    begin
        den_t = s1_x1_reg + md;
        num_t = mc <<< 11;
        den_t_mag = den_t[31] ? 32'(-den_t) : 32'(den_t);
        num_t_mag = num_t[31] ? 32'(-num_t) : 32'(num_t);
        neg_t = den_t[31] ^ num_t[31];
        err_t = (den_t == 32'sd0);
        side_t_in = {s1_x1_reg, s1_up_reg, err_t, neg_t};
    end

    bpc_div #(
        .NW(NT),
        .DW(DW),
        .SW(SIDE_T_W)
    ) u_div_t (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .in_valid(s1_v_reg),
        .num(num_t_mag[NT-1:0]),
        .den(den_t_mag),
        .side(side_t_in),
        .out_valid(dt_v),
        .quot(q_t),
        .out_side(side_t_out)
    );

    // Stage 3: B5.
    logic signed [31:0] x2_t;
    logic signed [31:0] dt_x1;
    logic               s3_v_reg;
    logic signed [31:0] s3_b5_reg;
    logic [15:0]        s3_up_reg;
    logic               s3_err_reg;

    always_comb
    begin
        dt_x1 = $signed(side_t_out[SIDE_T_W-1 -: 32]);
        x2_t = $signed({{(32-NT){1'b0}}, q_t});
        if (side_t_out[0])
        begin
            x2_t = -x2_t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_v_reg <= dt_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_b5_reg <= dt_x1 + x2_t;
            s3_up_reg <= side_t_out[17:2];
            s3_err_reg <= side_t_out[1];
        end
    end

    // Stage 4: temperature result, B6 and the products that need only B6.
    logic signed [31:0] b6;
    logic signed [31:0] t_full;
    logic signed [15:0] t_sat;
    logic signed [31:0] b6sq;
    logic               s4_v_reg;
    logic signed [15:0] s4_t_reg;
    logic signed [31:0] s4_sq_reg, s4_m2_reg, s4_m3_reg;
    logic [15:0]        s4_up_reg;
    logic               s4_err_reg;

    always_comb
    begin
        b6 = s3_b5_reg - bpc_pkg::K_B6_OFFSET;
        b6sq = b6 * b6;
        t_full = (s3_b5_reg + 32'sd8) >>> 4;
        if (t_full > bpc_pkg::T_MAX)
        begin
            t_sat = bpc_pkg::T_MAX[15:0];
        end
        else if (t_full < bpc_pkg::T_MIN)
        begin
            t_sat = bpc_pkg::T_MIN[15:0];
        end
        else
        begin
            t_sat = t_full[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_t_reg <= t_sat;
            s4_sq_reg <= b6sq >>> 12;
            s4_m2_reg <= ac2 * b6;
            s4_m3_reg <= ac3 * b6;
            s4_up_reg <= s3_up_reg;
            s4_err_reg <= s3_err_reg;
        end
    end

    // Stage 5: X3 for B3 and the sum for the scale term.
    logic signed [31:0] b2sq, b1sq;
    logic               s5_v_reg;
    logic signed [15:0] s5_t_reg;
    logic signed [31:0] s5_x3_reg, s5_y_reg;
    logic [15:0]        s5_up_reg;
    logic               s5_err_reg;

    always_comb
    begin
        b2sq = b2 * s4_sq_reg;
        b1sq = b1 * s4_sq_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_t_reg <= s4_t_reg;
            s5_x3_reg <= (b2sq >>> 11) + (s4_m2_reg >>> 11);
            s5_y_reg <= (s4_m3_reg >>> 13) + (b1sq >>> 16);
            s5_up_reg <= s4_up_reg;
            s5_err_reg <= s4_err_reg;
        end
    end

    // Stage 6: B3 and the factor that scales AC4.
    logic               s6_v_reg;
    logic signed [15:0] s6_t_reg;
    logic signed [31:0] s6_b3_reg, s6_c_reg;
    logic [15:0]        s6_up_reg;
    logic               s6_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s6_v_reg <= s5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_t_reg <= s5_t_reg;
            s6_b3_reg <= bpc_pkg::div4_trunc((ac1 <<< 2) + s5_x3_reg + 32'sd2);
            s6_c_reg <= bpc_pkg::div4_trunc(s5_y_reg + 32'sd2) + bpc_pkg::K_B4_OFFSET;
            s6_up_reg <= s5_up_reg;
            s6_err_reg <= s5_err_reg;
        end
    end

    // Stage 7: B4 and B7.
    logic [31:0] b4_prod, b7_next;
    logic        s7_v_reg;
    logic signed [15:0] s7_t_reg;
    logic [31:0] s7_b4_reg, s7_b7_reg;
    logic        s7_err_reg;

    always_comb
    begin
        b4_prod = {16'd0, ac4_reg} * s6_c_reg;
        b7_next = ({16'd0, s6_up_reg} - s6_b3_reg) * bpc_pkg::K_B7_SCALE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s7_v_reg <= s6_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_t_reg <= s6_t_reg;
            s7_b4_reg <= b4_prod >> 15;
            s7_b7_reg <= b7_next;
            s7_err_reg <= s6_err_reg;
        end
    end

    // Pressure divider. Small B7 is doubled before the division, large B7
    // has its quotient doubled after it.
    logic [NP-1:0]       num_p;
    logic [SIDE_P_W-1:0] side_p_in, side_p_out;
    logic                dp_v;
    logic [NP-1:0]       q_p;

    always_comb
    begin
        num_p = s7_b7_reg[31] ? s7_b7_reg : {s7_b7_reg[30:0], 1'b0};
        side_p_in = {s7_t_reg, s7_err_reg || (s7_b4_reg == 32'd0), s7_b7_reg[31]};
    end

    bpc_div #(
        .NW(NP),
        .DW(DW),
        .SW(SIDE_P_W)
    ) u_div_p (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .in_valid(s7_v_reg),
        .num(num_p),
        .den(s7_b4_reg),
        .side(side_p_in),
        .out_valid(dp_v),
        .quot(q_p),
        .out_side(side_p_out)
    );

    // Stage 8: first pressure estimate and its products.
    logic signed [31:0] p0, p0s;
    logic               s8_v_reg;
    logic signed [15:0] s8_t_reg;
    logic signed [31:0] s8_p_reg, s8_a_reg, s8_m_reg;
    logic               s8_err_reg;

    always_comb
    begin
        p0 = side_p_out[0] ? $signed({q_p[30:0], 1'b0}) : $signed(q_p);
        p0s = p0 >>> 8;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s8_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s8_v_reg <= dp_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_t_reg <= $signed(side_p_out[17:2]);
            s8_p_reg <= p0;
            s8_a_reg <= p0s * p0s;
            s8_m_reg <= bpc_pkg::K_P_LIN * p0;
            s8_err_reg <= side_p_out[1];
        end
    end

    // Stage 9: square term scaled.
    logic signed [31:0] sq_scaled;
    logic               s9_v_reg;
    logic signed [15:0] s9_t_reg;
    logic signed [31:0] s9_p_reg, s9_x1_reg, s9_x2_reg;
    logic               s9_err_reg;

    assign sq_scaled = s8_a_reg * bpc_pkg::K_P_SQ;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s9_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s9_v_reg <= s8_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s9_t_reg <= s8_t_reg;
            s9_p_reg <= s8_p_reg;
            s9_x1_reg <= sq_scaled >>> 16;
            s9_x2_reg <= s8_m_reg >>> 16;
            s9_err_reg <= s8_err_reg;
        end
    end

    // Stage 10: final correction, saturation and error zeroing.
    logic signed [31:0] p_corr, p_fin;
    logic [16:0]        p_sat;
    logic               out_valid_reg;
    logic signed [15:0] t_out_reg;
    logic [16:0]        p_out_reg;
    logic               err_out_reg;

    always_comb
    begin
        p_corr = s9_x1_reg + s9_x2_reg + bpc_pkg::K_P_OFS;
        p_fin = s9_p_reg + (p_corr >>> 4);
        if (p_fin < 32'sd0)
        begin
            p_sat = '0;
        end
        else if (p_fin > bpc_pkg::P_MAX)
        begin
            p_sat = bpc_pkg::P_MAX[16:0];
        end
        else
        begin
            p_sat = p_fin[16:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= s9_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_out_reg <= s9_err_reg ? 16'sd0 : s9_t_reg;
            p_out_reg <= s9_err_reg ? 17'd0 : p_sat;
            err_out_reg <= s9_err_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign temperature_tenths = t_out_reg;
    assign pressure_pa = p_out_reg;
    assign divide_error = err_out_reg;

endmodule
